/* hdl/fsrs_pkg.sv */
// package for the fitness scaled roulette select block: sizes, codes, states
package fsrs_pkg;
    localparam int POP_SIZE      = 64;
    localparam int FRACTION_BITS = 16;
    localparam int IDX_W         = $clog2(POP_SIZE);
    localparam int CNT_W         = $clog2(POP_SIZE + 1);
    localparam int W_W           = FRACTION_BITS + 1;
    localparam int SUM_W         = W_W + IDX_W;
    localparam int DRAW_BITS     = 16;
    localparam int LEN_DEN       = 25;
    localparam int LEN_MIN_NUM   = 20;
    localparam int LEN_STEPS     = 5;
    // scaled numerator is below 2^33 * 25 * 2^FRACTION_BITS
    localparam int NUM_W         = 33 + 5 + FRACTION_BITS;
    localparam int DEN_W         = 33 + 5;
    localparam int QUO_W         = W_W;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_SELECT  = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SC_READ,
        ST_SC_WAIT,
        ST_SC_DIV,
        ST_SC_WRITE,
        ST_TGT_MUL,
        ST_WK_READ,
        ST_WK_WAIT,
        ST_WK_TEST,
        ST_OUT
    } t_state;
endpackage

/* hdl/fsrs_ram.sv */
// generic single port ram with registered read
module fsrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/fitness_scaled_roulette_select.sv */
// Fitness proportionate selection with linear fitness scaling. Each beat
// carries one action. A load, a restart, the unused action and an empty
// select each give their result straight from idle. A select after new
// loads first rescales: per entry a registered read, a setup step, then a
// restoring divider at one quotient bit a cycle and a write; the divider is
// skipped when all fitnesses are equal. Every select then does one draw
// times sum multiply and walks the weight ram, one entry per read, wait and
// test step, until the running sum passes the target or the entries run out.
// The weight and fitness rams share one address port each.
// The block is not ready while a beat is in work or its result waits.
module fitness_scaled_roulette_select (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,      // generation_number [9:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,    // raw_fitness [31:0], random_draw [47:32]
    input  logic [1:0]  s_axis_tuser,    // action [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // selected_index [5:0], best_index [11:6],
                                         // loaded_count [18:12]
    output logic        m_axis_tuser     // fell_through
);
    import fsrs_pkg::*;

    t_state r_state, n_state;
    logic [9:0]         r_gen;
    logic [CNT_W-1:0]   r_count, n_count;
    logic signed [31:0] r_min, n_min, r_max, n_max;
    logic [IDX_W-1:0]   r_best, n_best;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic               r_ready_w, n_ready_w;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_sel, n_sel;
    logic               r_fell, n_fell;
    logic [DRAW_BITS-1:0] r_draw, n_draw;
    logic [SUM_W-1:0]   r_tgt, n_tgt;
    logic [SUM_W-1:0]   r_run, n_run;
    logic [NUM_W-1:0]   r_rem, n_rem;
    logic [DEN_W-1:0]   r_den, n_den;
    logic [QUO_W-1:0]   r_quo, n_quo;
    logic [5:0]         r_bit, n_bit;
    logic               r_ovalid, n_ovalid;

    logic               raw_we, w_we;
    logic [IDX_W-1:0]   raw_addr, w_addr;
    logic [31:0]        raw_rd;
    logic [W_W-1:0]     w_rd, w_wd;

    fsrs_ram #(.WIDTH(32), .DEPTH(POP_SIZE)) u_raw (
        .i_clk(i_clk), .i_we(raw_we), .i_addr(raw_addr),
        .i_wdata(s_axis_tdata[31:0]), .o_rdata(raw_rd));
    fsrs_ram #(.WIDTH(W_W), .DEPTH(POP_SIZE)) u_wt (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(w_wd), .o_rdata(w_rd));

    logic in_acc, out_acc;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = r_ovalid && m_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_fell;

    // scaling terms
    logic [32:0] d_val, off_val;
    logic [2:0]  g_step;
    logic [4:0]  n_len;
    logic [DEN_W-1:0] num_pre;
    assign d_val   = 33'($signed({r_max[31], r_max}) - $signed({r_min[31], r_min}));
    assign off_val = 33'($signed({raw_rd[31], raw_rd}) - $signed({r_min[31], r_min}));
    assign g_step  = (r_gen >= 10'(LEN_STEPS)) ? 3'(LEN_STEPS) : r_gen[2:0];
    assign n_len   = 5'(LEN_DEN) - 5'(g_step);
    assign num_pre = DEN_W'(off_val) * DEN_W'(n_len) + DEN_W'(d_val) * DEN_W'(g_step);

    // one restoring divide step
    logic [NUM_W:0] trial;
    assign trial = {r_rem, 1'b0};

    always_comb begin
        n_state = r_state; n_count = r_count; n_min = r_min; n_max = r_max;
        n_best = r_best; n_sum = r_sum; n_ready_w = r_ready_w; n_i = r_i;
        n_sel = r_sel; n_fell = r_fell; n_draw = r_draw; n_tgt = r_tgt;
        n_run = r_run; n_rem = r_rem; n_den = r_den; n_quo = r_quo;
        n_bit = r_bit; n_ovalid = r_ovalid;
        raw_we = 1'b0; w_we = 1'b0; raw_addr = r_i; w_addr = r_i;
        w_wd = r_quo;
        if (out_acc) n_ovalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_sel = '0; n_fell = 1'b0;
                    n_draw = s_axis_tdata[47:32];
                    case (t_action'(s_axis_tuser))
                        ACT_LOAD: begin
                            n_ovalid = 1'b1;
                            if (r_count < CNT_W'(POP_SIZE)) begin
                                raw_we = 1'b1;
                                raw_addr = r_count[IDX_W-1:0];
                                if (r_count == '0 ||
                                    $signed(s_axis_tdata[31:0]) < r_min)
                                    n_min = $signed(s_axis_tdata[31:0]);
                                if (r_count == '0 ||
                                    $signed(s_axis_tdata[31:0]) > r_max) begin
                                    n_max = $signed(s_axis_tdata[31:0]);
                                    n_best = r_count[IDX_W-1:0];
                                end
                                n_count = r_count + 1'b1;
                                n_ready_w = 1'b0;
                            end
                        end
                        ACT_SELECT: begin
                            if (r_count == '0) begin
                                n_fell = 1'b1; n_ovalid = 1'b1;
                            end else if (!r_ready_w) begin
                                n_i = '0; n_sum = '0; n_state = ST_SC_READ;
                            end else begin
                                n_state = ST_TGT_MUL;
                            end
                        end
                        ACT_RESTART: begin
                            n_count = '0; n_min = '0; n_max = '0; n_best = '0;
                            n_sum = '0; n_ready_w = 1'b0; n_ovalid = 1'b1;
                        end
                        default: n_ovalid = 1'b1;
                    endcase
                end
            end
            ST_SC_READ: n_state = ST_SC_WAIT;
            ST_SC_WAIT: begin
                if (d_val == '0) begin
                    n_quo = QUO_W'(1 << FRACTION_BITS);
                    n_state = ST_SC_WRITE;
                end else begin
                    n_rem = NUM_W'(num_pre);
                    n_den = DEN_W'(d_val) * DEN_W'(LEN_DEN);
                    n_quo = '0;
                    n_bit = 6'(NUM_W);
                    n_state = ST_SC_DIV;
                end
            end
            ST_SC_DIV: begin
                // long division of rem<<FRACTION_BITS by den, one bit a cycle;
                // rem holds the remainder, doubled each step as zero fraction bits come in
                n_bit = r_bit - 1'b1;
                if (r_bit == 6'(FRACTION_BITS + 1)) n_state = ST_SC_WRITE;
                n_rem = r_rem;
                n_quo = r_quo;
                if (r_bit == 6'(NUM_W)) begin
                    // first step: reduce the integer part (it is below 2*den)
                    if (r_rem >= NUM_W'(r_den)) begin
                        n_rem = r_rem - NUM_W'(r_den);
                        n_quo = QUO_W'(1);
                    end
                    n_bit = 6'(FRACTION_BITS);
                    n_state = ST_SC_DIV;
                end else begin
                    if (trial >= (NUM_W+1)'(r_den)) begin
                        n_rem = NUM_W'(trial - (NUM_W+1)'(r_den));
                        n_quo = {r_quo[QUO_W-2:0], 1'b1};
                    end else begin
                        n_rem = NUM_W'(trial);
                        n_quo = {r_quo[QUO_W-2:0], 1'b0};
                    end
                    if (r_bit == 6'd1) n_state = ST_SC_WRITE;
                    else n_state = ST_SC_DIV;
                end
            end
            ST_SC_WRITE: begin
                w_we = 1'b1;
                n_sum = r_sum + SUM_W'(r_quo);
                if (CNT_W'(r_i) + 1'b1 == r_count) begin
                    n_ready_w = 1'b1; n_state = ST_TGT_MUL;
                end else begin
                    n_i = r_i + 1'b1; n_state = ST_SC_READ;
                end
            end
            ST_TGT_MUL: begin
                n_tgt = SUM_W'(((SUM_W+DRAW_BITS)'(r_draw) * (SUM_W+DRAW_BITS)'(r_sum))
                        >> DRAW_BITS);
                n_i = '0; n_run = '0; n_state = ST_WK_READ;
            end
            ST_WK_READ: n_state = ST_WK_WAIT;
            ST_WK_WAIT: begin
                n_run = r_run + SUM_W'(w_rd);
                n_state = ST_WK_TEST;
            end
            ST_WK_TEST: begin
                if (r_run > r_tgt) begin
                    n_sel = r_i; n_state = ST_OUT;
                end else if (CNT_W'(r_i) + 1'b1 == r_count) begin
                    n_sel = '0; n_fell = 1'b1; n_state = ST_OUT;
                end else begin
                    n_i = r_i + 1'b1; n_state = ST_WK_READ;
                end
            end
            ST_OUT: begin
                n_ovalid = 1'b1; n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_gen <= '0; r_count <= '0; r_min <= '0;
            r_max <= '0; r_best <= '0; r_sum <= '0; r_ready_w <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_min <= n_min;
            r_max <= n_max; r_best <= n_best; r_sum <= n_sum;
            r_ready_w <= n_ready_w; r_ovalid <= n_ovalid;
            if (i_cfg_valid) r_gen <= i_cfg_data[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_sel <= n_sel; r_fell <= n_fell; r_draw <= n_draw;
        r_tgt <= n_tgt; r_run <= n_run; r_rem <= n_rem; r_den <= n_den;
        r_quo <= n_quo; r_bit <= n_bit;
    end

    // tdata carries selected, best and count, padded to three bytes
    logic [18:0] out_pack;
    assign out_pack = {r_count, r_best, r_sel};
    assign m_axis_tdata = {5'd0, out_pack};

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(POP_SIZE)) else $error("count overflow");
    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_fell |-> (CNT_W'(r_sel) < r_count || r_sel == '0))
        else $error("index beyond count");
`endif
endmodule

/* sim/fitness_scaled_roulette_select_tb.sv */
// testbench for fitness_scaled_roulette_select: stream driver, prediction and checking
module fitness_scaled_roulette_select_tb;
    import fsrs_pkg::*;

    // predicts the block's result for every accepted beat and checks results in order
    class roulette_scoreboard;
        typedef struct {
            logic [5:0] sel;
            logic       fell;
            logic [5:0] best;
            logic [6:0] count;
        } t_pick;

        t_pick      pending[$];
        longint     fit_mem[64];
        longint     wt_mem[64];
        int         count;
        longint     lo_fit;
        longint     hi_fit;
        int         best;
        longint     wsum;
        bit         ready;
        int         gen;
        int         errors;
        int         n_load;
        int         n_select;
        int         n_fell;
        int         n_rescale;

        function void clear_pop();
            count = 0;
            lo_fit = 0;
            hi_fit = 0;
            best = 0;
            wsum = 0;
            ready = 0;
        endfunction

        function void set_gen(int g);
            gen = g & 10'h3ff;
        endfunction

        function void rescale();
            longint n;
            longint d;
            longint num;
            n = (gen >= LEN_STEPS) ? LEN_MIN_NUM : LEN_DEN - gen;
            d = hi_fit - lo_fit;
            wsum = 0;
            for (int i = 0; i < count; i++) begin
                if (d == 0) begin
                    wt_mem[i] = 64'd1 << FRACTION_BITS;
                end else begin
                    num = (fit_mem[i] - lo_fit) * n + d * (LEN_DEN - n);
                    wt_mem[i] = (num <<< FRACTION_BITS) / (d * LEN_DEN);
                end
                wsum += wt_mem[i];
            end
            ready = 1;
            n_rescale++;
        endfunction

        function void note_input(t_action act, logic [31:0] raw, logic [15:0] draw);
            t_pick  p;
            longint f;
            longint target;
            longint run;
            bit     found;
            p.sel = '0;
            p.fell = 1'b0;
            f = longint'($signed(raw));
            case (act)
                ACT_LOAD: begin
                    n_load++;
                    if (count < POP_SIZE) begin
                        fit_mem[count] = f;
                        if (count == 0 || f < lo_fit) lo_fit = f;
                        if (count == 0 || f > hi_fit) begin
                            hi_fit = f;
                            best = count;
                        end
                        count++;
                        ready = 0;
                    end
                end
                ACT_SELECT: begin
                    n_select++;
                    if (count == 0) begin
                        p.fell = 1'b1;
                    end else begin
                        if (!ready) rescale();
                        target = (longint'(draw) * wsum) >> DRAW_BITS;
                        run = 0;
                        found = 0;
                        for (int i = 0; i < count && !found; i++) begin
                            run += wt_mem[i];
                            if (run > target) begin
                                p.sel = 6'(i);
                                found = 1;
                            end
                        end
                        if (!found) p.fell = 1'b1;
                    end
                    if (p.fell) n_fell++;
                end
                ACT_RESTART: clear_pop();
                default: ;
            endcase
            p.best = 6'(best);
            p.count = 7'(count);
            pending.push_back(p);
        endfunction

        function void check_result(logic [23:0] data, logic fell);
            t_pick p;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat: tdata=%h", data);
                return;
            end
            p = pending.pop_front();
            if (data[5:0] !== p.sel || fell !== p.fell || data[11:6] !== p.best
                || data[18:12] !== p.count || data[23:19] !== 5'd0) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp sel=%0d fell=%0d best=%0d cnt=%0d",
                             p.sel, p.fell, p.best, p.count);
                    $display("          got sel=%0d fell=%0d best=%0d cnt=%0d pad=%h",
                             data[5:0], fell, data[11:6], data[18:12], data[23:19]);
                end
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // raw_fitness [31:0], random_draw [47:32]
    logic [1:0]  s_axis_tuser = '0;   // action [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;        // selected_index [5:0], best_index [11:6], loaded_count [18:12]
    logic        m_axis_tuser;        // fell_through

    roulette_scoreboard sb = new();
    int burst_left = 0;
    int item_total = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int gens_seen[$];

    fitness_scaled_roulette_select dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // receiver: switches between always ready, random stalls and long stalls
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    task automatic send_beat(t_action act, logic [31:0] raw, logic [15:0] draw);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {draw, raw};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(act, raw, draw);
        burst_left--;
        item_total++;
    endtask

    // lowers valid, waits for every result and a further pause, then does a register write
    task automatic settle_and_config(int g);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= 16'(g);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_gen(g);
        gens_seen.push_back(g);
    endtask

    function automatic logic [31:0] pick_fitness(int mode, logic [31:0] base);
        case (mode)
            0:       return $urandom();
            1:       return base + $urandom_range(0, 40);
            2:       return base;
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0;
                    default: return $urandom();
                endcase
            end
        endcase
    endfunction

    initial begin
        int loads;
        int sels;
        int mode;
        int phase;
        logic [31:0] base;
        sb.clear_pop();
        sb.set_gen(0);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty select, unused action, extreme fitnesses and draws,
        // stale weights after a late load, equal fitnesses
        settle_and_config(0);
        send_beat(ACT_SELECT, 32'h0, 16'h1234);
        send_beat(ACT_NONE, 32'hffff_ffff, 16'hffff);
        send_beat(ACT_LOAD, 32'h8000_0000, 16'h0);
        send_beat(ACT_LOAD, 32'h7fff_ffff, 16'h0);
        send_beat(ACT_LOAD, 32'h0, 16'h0);
        send_beat(ACT_SELECT, 32'h0, 16'h0000);
        send_beat(ACT_SELECT, 32'h0, 16'hffff);
        send_beat(ACT_SELECT, 32'h0, 16'h8000);
        send_beat(ACT_LOAD, 32'hffff_fffb, 16'h0);
        send_beat(ACT_SELECT, 32'h0, 16'h5555);
        send_beat(ACT_RESTART, 32'h0, 16'h0);
        send_beat(ACT_SELECT, 32'h0, 16'hffff);
        settle_and_config(5);
        send_beat(ACT_LOAD, 32'd7, 16'h0);
        send_beat(ACT_LOAD, 32'd7, 16'h0);
        send_beat(ACT_LOAD, 32'd7, 16'h0);
        send_beat(ACT_SELECT, 32'h0, 16'h0000);
        send_beat(ACT_SELECT, 32'h0, 16'hffff);
        send_beat(ACT_NONE, 32'h0, 16'h0);
        settle_and_config(1023);
        send_beat(ACT_SELECT, 32'h0, 16'haaaa);
        send_beat(ACT_RESTART, 32'h0, 16'h0);

        // random phases: register write, restart, a population, then mostly selects with some loads and unused actions
        phase = 0;
        while (item_total < 1800) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: settle_and_config($urandom_range(0, 5));
                6:                settle_and_config(1023);
                7:                settle_and_config(0);
                default:          settle_and_config($urandom_range(0, 1023));
            endcase
            send_beat(ACT_RESTART, $urandom(), 16'($urandom()));
            if (phase % 25 == 0) loads = $urandom_range(64, 67);
            else if ($urandom_range(0, 9) < 7) loads = $urandom_range(0, 12);
            else loads = $urandom_range(13, 63);
            mode = $urandom_range(0, 3);
            base = $urandom();
            for (int i = 0; i < loads; i++)
                send_beat(ACT_LOAD, pick_fitness(mode, base), 16'($urandom()));
            sels = $urandom_range(4, 20);
            for (int i = 0; i < sels; i++) begin
                case ($urandom_range(0, 19))
                    0:       send_beat(ACT_LOAD, pick_fitness(mode, base), 16'($urandom()));
                    1:       send_beat(ACT_NONE, $urandom(), 16'($urandom()));
                    2:       send_beat(ACT_SELECT, $urandom(),
                                       $urandom_range(0, 1) ? 16'hffff : 16'h0);
                    default: send_beat(ACT_SELECT, $urandom(), 16'($urandom()));
                endcase
            end
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d beats: %0d loads, %0d selects (%0d fell through), %0d rescales",
                 item_total, sb.n_load, sb.n_select, sb.n_fell, sb.n_rescale);
        $display("%0d generation settings written, %0d failures", gens_seen.size(), sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("timeout with %0d results outstanding", sb.pending.size());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
